[rtl/midi_track_event_encoder_defines.svh]
// ----------------------------------------------------------------------------
// MIDI track event encoder: assertion macros
// Shared concurrent assertion helpers, clocked on clk_i, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef MIDI_TRACK_EVENT_ENCODER_DEFINES_SVH
`define MIDI_TRACK_EVENT_ENCODER_DEFINES_SVH

// Condition that must hold in the same cycle as its trigger
`define MTE_ASSERT_SAME(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Condition that must hold in the cycle after its trigger
`define MTE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/mte_pkg.sv]
// ----------------------------------------------------------------------------
// mte_pkg
// Types and constants shared by the MIDI track event encoder modules.
// ----------------------------------------------------------------------------
package mte_pkg;

  // Event kinds on the input channel
  typedef enum logic [2:0] {
    FUNC_NOTE_ON     = 3'd0,
    FUNC_NOTE_OFF    = 3'd1,
    FUNC_VOLUME      = 3'd2,
    FUNC_PROGRAM     = 3'd3,
    FUNC_END_OF_TRACK = 3'd4
  } func_e;

  localparam int unsigned MaxBytes   = 7;   // bytes per event, worst case
  localparam int unsigned DeltaBits  = 28;  // deltas of 2^28 and up are errors
  localparam int unsigned VlqGroups  = 4;
  localparam int unsigned QDepth     = 2;

  localparam logic [3:0] StNoteOff  = 4'h8;
  localparam logic [3:0] StNoteOn   = 4'h9;
  localparam logic [3:0] StControl  = 4'hB;
  localparam logic [3:0] StProgram  = 4'hC;
  localparam logic [7:0] StMeta     = 8'hFF;
  localparam logic [7:0] MetaEot    = 8'h2F;
  localparam logic [6:0] CtlVolume  = 7'h07;
  localparam logic [6:0] RelDefault = 7'h40;

  // One classified event: the bytes it sends and how many
  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;   // 1 to 7
    logic                     err;
  } ev_t;

  // Queue status seen by the front and back parts
  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

[rtl/midi_track_event_encoder.sv]
// The first byte of an event passes through the event queue and then the output
// register. One output byte per cycle while out_stall_i is low; an event is 1 to
// 7 bytes on the output port (delta bytes + optional status + data).
// A two-entry event queue lets a new event be taken while bytes still drain.
// Reset: running status 0xFF, previous time 0, queue and output register empty.
// ----------------------------------------------------------------------------
// midi_track_event_encoder
// Encodes track events into delta-time VLQ, running-status and data bytes.
// ----------------------------------------------------------------------------
module midi_track_event_encoder #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            func_i,
  input  logic [TIME_WIDTH-1:0] event_time_i,
  input  logic [3:0]            channel_i,
  input  logic [6:0]            key_i,
  input  logic [6:0]            velocity_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [7:0]            out_byte_o,
  output logic                  last_o,
  output logic                  error_o
);
  import mte_pkg::*;

  ev_t    ev_in, ev_head;
  qstat_t qstat;
  logic   push, pop;

  // Front: check and classify
  mte_front #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .func_i      (func_i),
    .event_time_i(event_time_i),
    .channel_i   (channel_i),
    .key_i       (key_i),
    .velocity_i  (velocity_i),
    .qstat_i     (qstat),
    .push_o      (push),
    .ev_o        (ev_in)
  );

  // Event queue
  mte_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .ev_i   (ev_in),
    .pop_i  (pop),
    .head_o (ev_head),
    .qstat_o(qstat)
  );

  // Back: byte serializer
  mte_emit u_emit (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .head_i     (ev_head),
    .qstat_i    (qstat),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_byte_o (out_byte_o),
    .last_o     (last_o),
    .error_o    (error_o)
  );

endmodule

[rtl/mte_front.sv]
// ----------------------------------------------------------------------------
// mte_front
// Accepts events, checks them, builds the byte list and keeps the running
// status and previous event time.
// ----------------------------------------------------------------------------
module mte_front #(
  parameter int unsigned TIME_WIDTH = 32
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic [2:0]            func_i,
  input  logic [TIME_WIDTH-1:0] event_time_i,
  input  logic [3:0]            channel_i,
  input  logic [6:0]            key_i,
  input  logic [6:0]            velocity_i,
  input  mte_pkg::qstat_t       qstat_i,
  output logic                  push_o,
  output mte_pkg::ev_t          ev_o
);
  import mte_pkg::*;

  logic [7:0]            rs_q, rs_d;
  logic [TIME_WIDTH-1:0] prev_q;

  logic [TIME_WIDTH-1:0]      delta;
  logic [VlqGroups-1:0][6:0]  grp;
  logic [2:0]                 ngrp;
  logic [7:0]                 st;
  logic [7:0]                 d0, d1;
  logic [1:0]                 nd;
  logic                       st_force, emit_st, bad, err;
  logic [2:0][7:0]            tail;
  logic [2:0]                 tcnt;
  logic [2:0]                 pos, j;

  // Delta and its seven-bit groups
  always_comb begin
    delta = event_time_i - prev_q;
    for (int k = 0; k < VlqGroups; k++) begin
      grp[k] = delta[7*k +: 7];
    end
    if (|grp[3])      ngrp = 3'd4;
    else if (|grp[2]) ngrp = 3'd3;
    else if (|grp[1]) ngrp = 3'd2;
    else              ngrp = 3'd1;
  end

  // Classify the event: status byte and data bytes
  always_comb begin
    st       = StMeta;
    d0       = '0;
    d1       = '0;
    nd       = 2'd2;
    st_force = 1'b0;
    bad      = 1'b0;
    case (func_e'(func_i))
      FUNC_NOTE_ON: begin
        st  = {StNoteOn, channel_i};
        d0  = {1'b0, key_i};
        d1  = {1'b0, velocity_i};
        bad = (velocity_i == '0);
      end
      FUNC_NOTE_OFF: begin
        d0 = {1'b0, key_i};
        if (velocity_i == RelDefault) begin
          st = {StNoteOn, channel_i};
          d1 = '0;
        end else begin
          st = {StNoteOff, channel_i};
          d1 = {1'b0, velocity_i};
        end
      end
      FUNC_VOLUME: begin
        st = {StControl, channel_i};
        d0 = {1'b0, CtlVolume};
        d1 = {1'b0, velocity_i};
      end
      FUNC_PROGRAM: begin
        st = {StProgram, channel_i};
        d0 = {1'b0, key_i};
        nd = 2'd1;
      end
      FUNC_END_OF_TRACK: begin
        st       = StMeta;
        d0       = MetaEot;
        st_force = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    emit_st = st_force || (st != rs_q);
    rs_d    = st;
    if (emit_st) begin
      tail = {d1, d0, st};
    end else begin
      tail = {8'h00, d1, d0};
    end
    tcnt = {1'b0, nd} + {2'b00, emit_st};
    err  = bad || (event_time_i < prev_q) || (|delta[TIME_WIDTH-1:DeltaBits]);
  end

  // Lay out delta bytes then the tail
  always_comb begin
    ev_o.err   = err;
    ev_o.count = err ? 3'd1 : (ngrp + tcnt);
    for (int i = 0; i < MaxBytes; i++) begin
      pos = 3'(i);
      j   = '0;
      if (err) begin
        ev_o.bytes[i] = '0;
      end else if (pos < ngrp) begin
        j = ngrp - 3'd1 - pos;
        ev_o.bytes[i] = {(pos != ngrp - 3'd1), grp[j[1:0]]};
      end else begin
        j = pos - ngrp;
        ev_o.bytes[i] = (j < 3'd3) ? tail[j[1:0]] : 8'h00;
      end
    end
  end

  assign in_stall_o = qstat_i.full;
  assign push_o     = in_valid_i && !qstat_i.full;

  // Track state moves only on good events
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rs_q   <= StMeta;
      prev_q <= '0;
    end else if (push_o && !err) begin
      rs_q   <= rs_d;
      prev_q <= event_time_i;
    end
  end

endmodule

[rtl/mte_queue.sv]
// ----------------------------------------------------------------------------
// mte_queue
// Two-entry queue of classified events between the front and back parts.
// ----------------------------------------------------------------------------
module mte_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  mte_pkg::ev_t    ev_i,
  input  logic            pop_i,
  output mte_pkg::ev_t    head_o,
  output mte_pkg::qstat_t qstat_o
);
  import mte_pkg::*;

  localparam int unsigned PtrW = $clog2(QDepth);

  ev_t                 ent_q [QDepth];
  logic [PtrW-1:0]     wr_q, rd_q;
  logic [PtrW:0]       cnt_q;

  assign qstat_o.full  = (cnt_q == (PtrW+1)'(QDepth));
  assign qstat_o.empty = (cnt_q == '0);
  assign head_o        = ent_q[rd_q];

  // Entry storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      ent_q[wr_q] <= ev_i;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(pop_i);
    end
  end

endmodule

[rtl/mte_emit.sv]
// ----------------------------------------------------------------------------
// mte_emit
// Walks the bytes of the head event and drives the output register.
// ----------------------------------------------------------------------------
`include "midi_track_event_encoder_defines.svh"

module mte_emit (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  mte_pkg::ev_t    head_i,
  input  mte_pkg::qstat_t qstat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [7:0]      out_byte_o,
  output logic            last_o,
  output logic            error_o
);
  import mte_pkg::*;

  logic [2:0] idx_q, idx_d;
  logic       vld_q, vld_d;
  logic [7:0] byte_q, byte_d;
  logic       last_q, last_d;
  logic       err_q, err_d;
  logic       load, is_last;

  // Next byte selection
  always_comb begin
    load    = !vld_q || !out_stall_i;
    is_last = (idx_q == head_i.count - 3'd1);
    idx_d   = idx_q;
    vld_d   = vld_q;
    byte_d  = byte_q;
    last_d  = last_q;
    err_d   = err_q;
    pop_o   = 1'b0;
    if (load) begin
      vld_d = !qstat_i.empty;
      if (!qstat_i.empty) begin
        byte_d = head_i.bytes[idx_q];
        last_d = is_last;
        err_d  = head_i.err;
        if (is_last) begin
          pop_o = 1'b1;
          idx_d = '0;
        end else begin
          idx_d = idx_q + 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      idx_q <= '0;
    end else begin
      vld_q <= vld_d;
      idx_q <= idx_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
    err_q  <= err_d;
  end

  assign out_valid_o = vld_q;
  assign out_byte_o  = byte_q;
  assign last_o      = last_q;
  assign error_o     = err_q;

  `MTE_ASSERT_SAME(a_err_shape, out_valid_o && error_o, last_o && (out_byte_o == 8'h00), "error transaction must be a single zero byte")
  `MTE_ASSERT_SAME(a_pop_nonempty, pop_o, !qstat_i.empty, "pop from empty queue")
  `MTE_ASSERT_SAME(a_idx_range, !qstat_i.empty, idx_q < head_i.count, "byte index past event length")
  `MTE_ASSERT_NEXT(a_pop_resets_idx, pop_o, idx_q == 3'd0, "byte index not cleared after event")

endmodule
